### design/ppdb_pkg.sv
// Shared types and constants for the ping-pong DMA buffer controller.
// Holds field widths, command and status codes, and the per-beat result record.
// No dependencies.
package ppdb_pkg;

  // Field widths of the stream beats
  localparam int CNT_W       = 15;
  localparam int OFF_W       = 14;
  localparam int STAT_W      = 3;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  // Default sizes handed to the top-level parameters
  localparam int unsigned DEF_BUFFER_BYTES = 16384;
  localparam int unsigned DEF_ALIGN_BYTES  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_POLL  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOROOM   = 3'd3,
    ST_XFER_ERR = 3'd4
  } status_t;

  // Result fields that leave the control stage; transfer_length is added later
  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  accepted_count;
    logic              copy_buffer;
    logic [OFF_W-1:0]  copy_offset;
    logic              start_transfer;
    logic              transfer_buffer;
    logic [CNT_W-1:0]  pad_start;
    logic              wr_ready;
  } res_t;

endpackage

### design/ppdb_ctrl.sv
// Buffer ownership state and per-command decision logic.
// Tracks fill buffer, running transfer and fill position; builds one result per beat.
// Depends on ppdb_pkg.
module ppdb_ctrl import ppdb_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int          POS_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  cmd_t             cmd,
  input  logic [CNT_W-1:0] byte_count,
  input  logic             transfer_ok,
  output res_t             res,
  output logic [POS_W-1:0] xfer_len
);

  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic             fill_idx_r, fill_idx_nxt;
  logic             act_v_r, act_v_nxt;
  logic             act_i_r, act_i_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pend_r, pend_nxt;

  logic             blocked;
  logic [POS_W-1:0] room;
  logic [POS_W-1:0] clamp;
  logic [POS_W-1:0] pos_sum;
  logic             hand;
  logic [POS_W-1:0] hand_len;

  assign blocked = act_v_r && (act_i_r == fill_idx_r);
  assign room    = POS_W'(BUFFER_BYTES) - pos_r;
  assign clamp   = (CMP_W'(byte_count) > CMP_W'(room)) ? room : POS_W'(byte_count);
  assign pos_sum = pos_r + clamp;

  // Decide the command and the next state
  always_comb begin
    fill_idx_nxt = fill_idx_r;
    act_v_nxt    = act_v_r;
    act_i_nxt    = act_i_r;
    pos_nxt      = pos_r;
    pend_nxt     = pend_r;
    res          = '0;
    res.status   = ST_OK;
    xfer_len     = '0;
    hand         = 1'b0;
    hand_len     = '0;

    case (cmd)
      CMD_WRITE: begin
        if (blocked) begin
          res.status = ST_BUSY;
        end else if (clamp == '0) begin
          res.status = ST_NOROOM;
        end else begin
          res.accepted_count = CNT_W'(clamp);
          res.copy_buffer    = fill_idx_r;
          res.copy_offset    = OFF_W'(pos_r);
          pos_nxt            = pos_sum;
          if (pos_sum == POS_W'(BUFFER_BYTES)) begin
            hand     = 1'b1;
            hand_len = POS_W'(BUFFER_BYTES);
          end
        end
      end
      CMD_FLUSH: begin
        if (pos_r == '0) begin
          res.status = ST_EMPTY;
        end else if (blocked) begin
          res.status = ST_BUSY;
        end else begin
          res.accepted_count = CNT_W'(pos_r);
          hand               = 1'b1;
          hand_len           = pos_r;
        end
      end
      CMD_DONE: begin
        if (!transfer_ok) begin
          res.status = ST_XFER_ERR;
        end else if (blocked) begin
          // queued buffer goes out next
          act_i_nxt           = ~act_i_r;
          res.start_transfer  = 1'b1;
          res.transfer_buffer = ~act_i_r;
          res.pad_start       = CNT_W'(pend_r);
          xfer_len            = pend_r;
        end else begin
          act_v_nxt = 1'b0;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase

    // Hand the fill buffer over, starting it at once when the engine is free
    if (hand) begin
      if (!act_v_r) begin
        act_v_nxt           = 1'b1;
        act_i_nxt           = fill_idx_r;
        res.start_transfer  = 1'b1;
        res.transfer_buffer = fill_idx_r;
        res.pad_start       = CNT_W'(hand_len);
        xfer_len            = hand_len;
      end
      pend_nxt     = hand_len;
      fill_idx_nxt = ~fill_idx_r;
      pos_nxt      = '0;
    end

    res.wr_ready = !(act_v_nxt && (act_i_nxt == fill_idx_nxt));
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_idx_r <= 1'b0;
      act_v_r    <= 1'b0;
      act_i_r    <= 1'b0;
      pos_r      <= '0;
      pend_r     <= '0;
    end else if (fire) begin
      fill_idx_r <= fill_idx_nxt;
      act_v_r    <= act_v_nxt;
      act_i_r    <= act_i_nxt;
      pos_r      <= pos_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

### design/ppdb_round.sv
// Two-stage round-up of a transfer length to a multiple of ALIGN_BYTES.
// Stage one takes the quotient by reciprocal multiply, stage two scales it back.
// Depends on ppdb_pkg.
module ppdb_round import ppdb_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int unsigned ALIGN_BYTES  = DEF_ALIGN_BYTES,
  parameter int          POS_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  logic             clk,
  input  logic             en_q,
  input  logic             en_len,
  input  logic [POS_W-1:0] len,
  output logic [CNT_W-1:0] transfer_length
);

  // Numerator len + ALIGN - 1 stays below 2**N_W
  localparam int N_W   = $clog2(BUFFER_BYTES + ALIGN_BYTES);
  localparam int L_W   = $clog2(ALIGN_BYTES);
  localparam int SH    = N_W + L_W;
  localparam int MUL_W = N_W + 1;
  localparam int PW    = N_W + MUL_W;
  localparam int QW    = N_W - L_W + 1;
  localparam int TW    = QW + L_W + 1;
  localparam longint unsigned MUL = ((64'd1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

  logic [N_W-1:0]   num;
  logic [PW-1:0]    prod;
  logic [QW-1:0]    q_r;
  logic [TW-1:0]    scaled;
  logic [CNT_W-1:0] tlen_r;

  assign num    = N_W'(len) + N_W'(ALIGN_BYTES - 1);
  assign prod   = PW'(num) * PW'(MUL);
  assign scaled = TW'(q_r) * TW'(ALIGN_BYTES);

  // Hold the quotient, then the rounded length
  always_ff @(posedge clk) begin
    if (en_q) begin
      q_r <= QW'(prod >> SH);
    end
    if (en_len) begin
      tlen_r <= CNT_W'(scaled);
    end
  end

  assign transfer_length = tlen_r;

endmodule

### design/ping_pong_dma_buffer_control.sv
// Top level of the ping-pong DMA buffer controller.
// Instantiates ppdb_ctrl and ppdb_round; depends on ppdb_pkg.
//
//   channel  direction  beat contents (lowest bits first)
//   in_      slave      tuser: command; tdata: byte_count, transfer_ok
//   out_     master     tdata: status .. wr_ready, one result per input beat
//
// From input beat to result beat, the control stage, the reciprocal-multiply
// stage and the scale-back stage each hold one register.
// One beat is taken per cycle while out_tready lets the stages drain; buffer
// state updates in the cycle a beat is taken. Each stage refills as soon as the
// next one frees, so input beats are still taken while a result waits, until all three stages hold a beat.
// rst_n clears the state and the stage valid bits.
module ping_pong_dma_buffer_control import ppdb_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int unsigned ALIGN_BYTES  = DEF_ALIGN_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // byte_count[14:0], transfer_ok[15]
  input  logic [CMD_W-1:0]       in_tuser,   // command[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[2:0], accepted_count[17:3], copy_buffer[18], copy_offset[32:19],
  // start_transfer[33], transfer_buffer[34], transfer_length[49:35],
  // pad_start[64:50], wr_ready[65], zero fill [71:66]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);

  logic             fire;
  res_t             ctrl_res;
  logic [POS_W-1:0] ctrl_len;

  logic             s1_v_r, s2_v_r, s3_v_r;
  res_t             s1_res_r, s2_res_r, s3_res_r;
  logic [POS_W-1:0] s1_len_r;
  logic             adv1, adv2, adv3;
  logic [CNT_W-1:0] tlen;

  // Stage advance: a stage loads when empty or when its contents move on
  assign adv3      = !s3_v_r || out_tready;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign in_tready = adv1;
  assign fire      = in_tvalid && in_tready;

  ppdb_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .POS_W        (POS_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd         (cmd_t'(in_tuser)),
    .byte_count  (in_tdata[CNT_W-1:0]),
    .transfer_ok (in_tdata[CNT_W]),
    .res         (ctrl_res),
    .xfer_len    (ctrl_len)
  );

  ppdb_round #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .POS_W        (POS_W)
  ) u_round (
    .clk             (clk),
    .en_q            (adv2),
    .en_len          (adv3),
    .len             (s1_len_r),
    .transfer_length (tlen)
  );

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= fire;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  // Payload of the three stages
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_res_r <= ctrl_res;
      s1_len_r <= ctrl_len;
    end
    if (adv2) begin
      s2_res_r <= s1_res_r;
    end
    if (adv3) begin
      s3_res_r <= s2_res_r;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {6'b0,
                       s3_res_r.wr_ready,
                       s3_res_r.pad_start,
                       tlen,
                       s3_res_r.transfer_buffer,
                       s3_res_r.start_transfer,
                       s3_res_r.copy_offset,
                       s3_res_r.copy_buffer,
                       s3_res_r.accepted_count,
                       s3_res_r.status};

endmodule
